// ===== rtl/core/dq_pkg.sv =====
// ============================================================================
// dq_pkg
// shared types, codes and sizes for the double-ended queue
// ============================================================================
package dq_pkg;

    localparam int DEPTH  = 16;
    localparam int WORD_W = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;

    // request kinds
    typedef enum logic [2:0] {
        KIND_DUMP_FWD   = 3'd0,
        KIND_DUMP_REV   = 3'd1,
        KIND_PUSH_FRONT = 3'd2,
        KIND_PUSH_BACK  = 3'd3,
        KIND_POP_FRONT  = 3'd4,
        KIND_POP_BACK   = 3'd5
    } t_kind;

    // result status
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    // per-cell load select
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_FROM_PREV,
        CELL_FROM_NEXT,
        CELL_LOAD_VALUE,
        CELL_LOAD_HEAD,
        CELL_LOAD_TAIL
    } t_cell_op;

    // everything a cell sees besides its two neighbors
    typedef struct packed {
        t_cell_op op;
        t_word    value;
        t_word    head;
        t_word    tail;
    } t_cell_ctl;

endpackage

// ===== rtl/core/dq_ifs.sv =====
// ============================================================================
// dq request / result channels
// valid-ready channels carrying one request or one result
// ============================================================================
interface dq_req_if;
    logic          valid;
    logic          ready;
    logic [2:0]    kind;
    dq_pkg::t_word value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface dq_rsp_if;
    logic          valid;
    logic          ready;
    dq_pkg::t_word word;
    logic [1:0]    status;
    logic          last;

    modport source (output valid, output word, output status, output last, input ready);
    modport sink   (input valid, input word, input status, input last, output ready);
endinterface

// ===== rtl/core/dq_cell.sv =====
// ============================================================================
// dq_cell
// one queue slot: holds a word, loads from a neighbor or a broadcast source
// ============================================================================
module dq_cell (
    input  logic              i_clk,
    input  dq_pkg::t_cell_ctl i_ctl,
    input  dq_pkg::t_word     i_prev,
    input  dq_pkg::t_word     i_next,
    output dq_pkg::t_word     o_data
);

    dq_pkg::t_word r_data;
    dq_pkg::t_word n_data;

    always_comb begin
        case (i_ctl.op)
            dq_pkg::CELL_HOLD:       n_data = r_data;
            dq_pkg::CELL_FROM_PREV:  n_data = i_prev;
            dq_pkg::CELL_FROM_NEXT:  n_data = i_next;
            dq_pkg::CELL_LOAD_VALUE: n_data = i_ctl.value;
            dq_pkg::CELL_LOAD_HEAD:  n_data = i_ctl.head;
            dq_pkg::CELL_LOAD_TAIL:  n_data = i_ctl.tail;
            default:                 n_data = r_data;
        endcase
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// ============================================================================
// double_ended_queue
// bounded deque of signed words kept in a row of shifting cells
// ============================================================================
//
//  channel   dir   payload                          handshake
//  --------  ----  -------------------------------  ---------------------
//  i_req     in    kind[2:0], value[31:0] signed    valid / ready
//  o_rsp     out   word[31:0] signed, status[1:0],  valid / ready
//                  last
//
//  push/pop: one result each; dump: the request is taken, then each held entry
//  is sent in turn through the single output register (empty: one empty result)
//  a new request is taken while idle and the output register is free or
//  being drained in the same cycle
//  i_rst_n (synchronous, low) empties the queue; cell contents are not cleared
//  a stall on o_rsp freezes the dump sequence and blocks new requests
//
// outside a dump, cell k holds the k-th entry from the front:
//   push front  - whole row shifts toward the back, cell 0 loads the value
//   push back   - cell[count] loads the value
//   pop front   - whole row shifts toward the front
//   pop back    - tail cell read, count drops
//   dump fwd    - head is sent, occupied cells rotate toward the front
//   dump rev    - tail is sent, occupied cells rotate toward the back
// after count rotation steps the row is back in its original order
// ============================================================================
module double_ended_queue (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dq_req_if.sink   i_req,
    dq_rsp_if.source o_rsp
);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    // what the cell row does this cycle
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_PUSH_FRONT,
        ACT_PUSH_BACK,
        ACT_POP_FRONT,
        ACT_ROT_FWD,
        ACT_ROT_REV
    } t_act;

    t_state           r_state,  n_state;
    dq_pkg::t_cnt     r_count,  n_count;   // occupancy
    dq_pkg::t_cnt     r_remain, n_remain;  // dump words still to send
    logic             r_rev,    n_rev;     // dump direction
    logic             r_valid,  n_valid;
    dq_pkg::t_word    r_word,   n_word;
    dq_pkg::t_status  r_status, n_status;
    logic             r_last,   n_last;

    t_act             w_act;
    logic             w_out_free;
    logic             w_accept;
    logic             w_step;
    dq_pkg::t_idx     w_tail_idx;
    dq_pkg::t_word    w_head;
    dq_pkg::t_word    w_tail;
    dq_pkg::t_word    w_cell_data [dq_pkg::DEPTH];
    dq_pkg::t_cell_ctl w_cell_ctl [dq_pkg::DEPTH];

    // output slot can take a new result
    assign w_out_free = !r_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_step      = (r_state == S_DUMP) && w_out_free;

    // head and tail taps of the row
    assign w_tail_idx = dq_pkg::IDX_W'(r_count - dq_pkg::CNT_W'(1));
    assign w_head     = w_cell_data[0];
    assign w_tail     = w_cell_data[w_tail_idx];

    // ------------------------------------------------------------------------
    // request decode and next state
    // ------------------------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_remain = r_remain;
        n_rev    = r_rev;
        n_valid  = r_valid && !o_rsp.ready;
        n_word   = r_word;
        n_status = r_status;
        n_last   = r_last;
        w_act    = ACT_NONE;

        if (w_accept) begin
            case (i_req.kind)
                dq_pkg::KIND_DUMP_FWD,
                dq_pkg::KIND_DUMP_REV: begin
                    if (r_count == '0) begin
                        n_valid  = 1'b1;
                        n_word   = '0;
                        n_status = dq_pkg::STAT_EMPTY;
                        n_last   = 1'b1;
                    end else begin
                        n_state  = S_DUMP;
                        n_remain = r_count;
                        n_rev    = (i_req.kind == dq_pkg::KIND_DUMP_REV);
                    end
                end
                dq_pkg::KIND_PUSH_FRONT,
                dq_pkg::KIND_PUSH_BACK: begin
                    n_valid = 1'b1;
                    n_last  = 1'b1;
                    if (r_count == dq_pkg::CNT_W'(dq_pkg::DEPTH)) begin
                        n_word   = '0;
                        n_status = dq_pkg::STAT_FULL;
                    end else begin
                        n_word   = i_req.value;
                        n_status = dq_pkg::STAT_OK;
                        n_count  = r_count + dq_pkg::CNT_W'(1);
                        w_act    = (i_req.kind == dq_pkg::KIND_PUSH_FRONT)
                                   ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
                    end
                end
                dq_pkg::KIND_POP_FRONT,
                dq_pkg::KIND_POP_BACK: begin
                    n_valid = 1'b1;
                    n_last  = 1'b1;
                    if (r_count == '0) begin
                        n_word   = '0;
                        n_status = dq_pkg::STAT_EMPTY;
                    end else begin
                        n_status = dq_pkg::STAT_OK;
                        n_count  = r_count - dq_pkg::CNT_W'(1);
                        if (i_req.kind == dq_pkg::KIND_POP_FRONT) begin
                            n_word = w_head;
                            w_act  = ACT_POP_FRONT;
                        end else begin
                            n_word = w_tail;
                        end
                    end
                end
                default: begin
                    // unused kind codes: dropped without a result
                end
            endcase
        end else if (w_step) begin
            // one dumped word per free output slot
            n_valid  = 1'b1;
            n_word   = r_rev ? w_tail : w_head;
            n_status = dq_pkg::STAT_OK;
            n_last   = (r_remain == dq_pkg::CNT_W'(1));
            n_remain = r_remain - dq_pkg::CNT_W'(1);
            w_act    = r_rev ? ACT_ROT_REV : ACT_ROT_FWD;
            if (r_remain == dq_pkg::CNT_W'(1)) begin
                n_state = S_IDLE;
            end
        end
    end

    // ------------------------------------------------------------------------
    // per-cell load select
    // ------------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < dq_pkg::DEPTH; i++) begin
            w_cell_ctl[i].value = i_req.value;
            w_cell_ctl[i].head  = w_head;
            w_cell_ctl[i].tail  = w_tail;
            w_cell_ctl[i].op    = dq_pkg::CELL_HOLD;
            case (w_act)
                ACT_PUSH_FRONT: begin
                    w_cell_ctl[i].op = (i == 0) ? dq_pkg::CELL_LOAD_VALUE
                                                : dq_pkg::CELL_FROM_PREV;
                end
                ACT_PUSH_BACK: begin
                    if (dq_pkg::CNT_W'(i) == r_count) begin
                        w_cell_ctl[i].op = dq_pkg::CELL_LOAD_VALUE;
                    end
                end
                ACT_POP_FRONT: begin
                    w_cell_ctl[i].op = dq_pkg::CELL_FROM_NEXT;
                end
                ACT_ROT_FWD: begin
                    // occupied cells rotate toward the front, head wraps to tail
                    if (dq_pkg::CNT_W'(i) + dq_pkg::CNT_W'(1) == r_count) begin
                        w_cell_ctl[i].op = dq_pkg::CELL_LOAD_HEAD;
                    end else if (dq_pkg::CNT_W'(i) < r_count) begin
                        w_cell_ctl[i].op = dq_pkg::CELL_FROM_NEXT;
                    end
                end
                ACT_ROT_REV: begin
                    // occupied cells rotate toward the back, tail wraps to head
                    if (i == 0) begin
                        w_cell_ctl[i].op = dq_pkg::CELL_LOAD_TAIL;
                    end else if (dq_pkg::CNT_W'(i) < r_count) begin
                        w_cell_ctl[i].op = dq_pkg::CELL_FROM_PREV;
                    end
                end
                default: begin
                    w_cell_ctl[i].op = dq_pkg::CELL_HOLD;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // row of cells
    // ------------------------------------------------------------------------
    for (genvar g = 0; g < dq_pkg::DEPTH; g++) begin : g_cell
        dq_pkg::t_word w_prev;
        dq_pkg::t_word w_next;

        if (g == 0) begin : g_first
            assign w_prev = w_cell_data[g];
        end else begin : g_mid_prev
            assign w_prev = w_cell_data[g-1];
        end

        if (g == dq_pkg::DEPTH - 1) begin : g_final
            assign w_next = w_cell_data[g];
        end else begin : g_mid_next
            assign w_next = w_cell_data[g+1];
        end

        dq_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_cell_ctl[g]),
            .i_prev (w_prev),
            .i_next (w_next),
            .o_data (w_cell_data[g])
        );
    end

    // ------------------------------------------------------------------------
    // state and output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_remain <= '0;
            r_rev    <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_remain <= n_remain;
            r_rev    <= n_rev;
            r_valid  <= n_valid;
        end
        r_word   <= n_word;
        r_status <= n_status;
        r_last   <= n_last;
    end

    assign o_rsp.valid  = r_valid;
    assign o_rsp.word   = r_word;
    assign o_rsp.status = r_status;
    assign o_rsp.last   = r_last;

endmodule

// ===== test/deque_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// deque_checker
// shadows the deque contents from accepted requests, queues the results each
// request must give and compares them field by field as they are accepted
// ============================================================================
module deque_checker
    import dq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [2:0]  i_req_kind,
    input  t_word       i_req_value,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  t_word       i_rsp_word,
    input  logic [1:0]  i_rsp_status,
    input  logic        i_rsp_last,
    output int          o_mismatches,
    output int          o_pending
);

    typedef struct {
        t_word   word;
        t_status status;
        logic    last;
    } t_result;

    // ring copy of the queued words
    t_word       shadow_words [DEPTH];
    int unsigned shadow_front;
    int unsigned shadow_count;

    t_result     expected_results [$];
    t_result     oldest;
    int          mismatch_total = 0;

    assign o_mismatches = mismatch_total;

    function automatic void expect_result(t_word word, t_status status, logic last);
        t_result r;
        r.word   = word;
        r.status = status;
        r.last   = last;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_request(logic [2:0] kind, t_word value);
        int unsigned n;
        int unsigned slot;
        case (kind)
            KIND_DUMP_FWD, KIND_DUMP_REV: begin
                if (shadow_count == 0)
                    expect_result('0, STAT_EMPTY, 1'b1);
                for (n = 0; n < shadow_count; n++) begin
                    if (kind == KIND_DUMP_FWD)
                        slot = (shadow_front + n) % DEPTH;
                    else
                        slot = (shadow_front + shadow_count - 1 - n) % DEPTH;
                    expect_result(shadow_words[slot], STAT_OK, n + 1 == shadow_count);
                end
            end
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                if (shadow_count >= DEPTH) begin
                    expect_result('0, STAT_FULL, 1'b1);
                end else begin
                    if (kind == KIND_PUSH_FRONT) begin
                        shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                        shadow_words[shadow_front] = value;
                    end else begin
                        shadow_words[(shadow_front + shadow_count) % DEPTH] = value;
                    end
                    shadow_count++;
                    expect_result(value, STAT_OK, 1'b1);
                end
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
                if (shadow_count == 0) begin
                    expect_result('0, STAT_EMPTY, 1'b1);
                end else begin
                    if (kind == KIND_POP_FRONT) begin
                        slot = shadow_front;
                        shadow_front = (shadow_front + 1) % DEPTH;
                    end else begin
                        slot = (shadow_front + shadow_count - 1) % DEPTH;
                    end
                    shadow_count--;
                    expect_result(shadow_words[slot], STAT_OK, 1'b1);
                end
            end
            default: ;  // unused codes leave everything as it was
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_front = 0;
            shadow_count = 0;
            expected_results.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual word %0d status %0d last %0b",
                             $time, i_rsp_word, i_rsp_status, i_rsp_last);
                    mismatch_total++;
                end else begin
                    oldest = expected_results.pop_front();
                    if (i_rsp_word !== oldest.word || i_rsp_status !== oldest.status ||
                        i_rsp_last !== oldest.last) begin
                        $display("%0t result mismatch: expected word %0d status %0d last %0b, %s",
                                 $time, oldest.word, oldest.status, oldest.last, "actual");
                        $display("%0t   actual word %0d status %0d last %0b",
                                 $time, i_rsp_word, i_rsp_status, i_rsp_last);
                        mismatch_total++;
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                predict_request(i_req_kind, i_req_value);
        end
        o_pending <= expected_results.size();
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb
// drives directed and random requests into the double-ended queue under
// bursty input and stalling output, and reports the checker's verdict
// ============================================================================
module tb;
    import dq_pkg::*;

    // request codes the block has no use for
    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    localparam int RANDOM_REQUESTS = 90;
    localparam int HOLD_START      = 100;   // cycles after reset
    localparam int HOLD_CYCLES     = 120;
    localparam int DRAIN_CYCLES    = 40;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int   mismatches;
    int   pending_results;

    // sender burst bookkeeping
    int   burst_left = 0;

    dq_req_if req_ch ();
    dq_rsp_if rsp_ch ();

    double_ended_queue DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    deque_checker SCB (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_ch.valid),
        .i_req_ready  (req_ch.ready),
        .i_req_kind   (req_ch.kind),
        .i_req_value  (req_ch.value),
        .i_rsp_valid  (rsp_ch.valid),
        .i_rsp_ready  (rsp_ch.ready),
        .i_rsp_word   (rsp_ch.word),
        .i_rsp_status (rsp_ch.status),
        .i_rsp_last   (rsp_ch.last),
        .o_mismatches (mismatches),
        .o_pending    (pending_results)
    );

    always #5 i_clk = ~i_clk;

    // mostly arbitrary words, now and then one of the extremes
    function automatic t_word pick_word();
        case ($urandom_range(15, 0))
            0:       return t_word'(32'h8000_0000);
            1:       return t_word'(32'h7fff_ffff);
            2:       return '0;
            3:       return '1;
            default: return t_word'($urandom());
        endcase
    endfunction

    // weighted pick between push, pop and dump, either end at random
    function automatic logic [2:0] pick_kind(int push_pct, int pop_pct);
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < push_pct)
            return $urandom_range(1, 0) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
        else if (roll < push_pct + pop_pct)
            return $urandom_range(1, 0) ? KIND_POP_FRONT : KIND_POP_BACK;
        else
            return $urandom_range(1, 0) ? KIND_DUMP_FWD : KIND_DUMP_REV;
    endfunction

    // offer one request, opening a new burst (maybe after a gap) when the
    // last one ran out; returns at the edge where the request was taken
    task automatic issue_request(input logic [2:0] kind, input t_word value);
        int gap;
        if (burst_left == 0) begin
            // one burst in five is a long gapless stretch
            burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(40, 20)
                                                     : $urandom_range(8, 1);
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.kind  <= kind;
        req_ch.value <= value;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // request side: reset, directed requests, random requests, verdict
    initial begin : request_source
        int sent;
        int n;
        int phase;
        int phase_left;
        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.kind  <= KIND_DUMP_FWD;
        req_ch.value <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue: pops and dumps from both ends report empty
        issue_request(KIND_POP_FRONT, pick_word());
        issue_request(KIND_POP_BACK, pick_word());
        issue_request(KIND_DUMP_FWD, pick_word());
        issue_request(KIND_DUMP_REV, pick_word());

        // spare codes must give nothing
        issue_request(KIND_SPARE_LO, pick_word());
        issue_request(KIND_SPARE_HI, pick_word());

        // fill to the brim from both ends, extremes first, wrapping the front
        issue_request(KIND_PUSH_FRONT, t_word'(32'h8000_0000));
        issue_request(KIND_PUSH_BACK, t_word'(32'h7fff_ffff));
        issue_request(KIND_PUSH_FRONT, '1);
        issue_request(KIND_PUSH_BACK, '0);
        for (n = 4; n < DEPTH; n++)
            issue_request((n % 2) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, t_word'($urandom()));

        // full queue: pushes are dropped, dumps stream all sixteen words
        issue_request(KIND_PUSH_FRONT, pick_word());
        issue_request(KIND_PUSH_BACK, pick_word());
        issue_request(KIND_DUMP_FWD, pick_word());
        issue_request(KIND_DUMP_REV, pick_word());
        issue_request(KIND_POP_FRONT, pick_word());
        issue_request(KIND_POP_BACK, pick_word());

        // random requests in phases that lean toward filling, draining or
        // neither, so the queue swings between empty and full
        sent       = 0;
        phase      = 0;
        phase_left = 0;
        while (sent < RANDOM_REQUESTS) begin
            if (phase_left == 0) begin
                phase      = $urandom_range(2, 0);
                phase_left = $urandom_range(24, 8);
            end
            phase_left--;
            if ($urandom_range(49, 0) == 0) begin
                issue_request($urandom_range(1, 0) ? KIND_SPARE_LO : KIND_SPARE_HI,
                              pick_word());
            end else begin
                case (phase)
                    0:       issue_request(pick_kind(75, 15), pick_word());
                    1:       issue_request(pick_kind(15, 75), pick_word());
                    default: issue_request(pick_kind(40, 45), pick_word());
                endcase
                sent++;
            end
        end
        req_ch.valid <= 1'b0;

        // let the checker see the last request, then drain every result
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: the ready pattern is redrawn at random, plus one long
    // hold-off so the output register backs up and the block refuses requests
    initial begin : result_sink
        int   cycle_count;
        int   mode;
        logic take;
        cycle_count = 0;
        mode        = 0;
        rsp_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (cycle_count % 40 == 0)
                mode = $urandom_range(3, 0);
            if (cycle_count >= HOLD_START && cycle_count < HOLD_START + HOLD_CYCLES) begin
                take = 1'b0;
            end else begin
                case (mode)
                    0:       take = 1'b1;                          // no stalls
                    1:       take = 1'($urandom_range(1, 0));      // coin toss
                    2:       take = (cycle_count % 4 == 0);        // one in four
                    default: take = ($urandom_range(9, 0) != 0);   // rare stalls
                endcase
            end
            rsp_ch.ready <= take;
            @(posedge i_clk);
            cycle_count++;
        end
    end

    // hard stop well beyond the slowest legal run
    initial begin : watchdog
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/dq_pkg.sv
rtl/core/dq_ifs.sv
rtl/core/dq_cell.sv
rtl/core/double_ended_queue.sv
test/deque_checker.sv
test/tb.sv
